@@ src/tkis_pkg.sv @@
// ----------------------------------------------------------------------------
// tkis_pkg
// Shared constants and types for the two-key index sorter.
// ----------------------------------------------------------------------------
package tkis_pkg;

  // Default capacity of the sorting chain and default key width.
  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_KEY_BITS     = 32;

  // Width of a load position on the result channel.
  localparam int POS_BITS = 6;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the incoming element in sorted order
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

@@ src/tkis_cell.sv @@
// ----------------------------------------------------------------------------
// tkis_cell
// One slot of the sorting chain: holds an element and trades with neighbors.
// ----------------------------------------------------------------------------
module tkis_cell #(
  parameter int KEY_BITS = tkis_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tkis_pkg::cell_ctrl_t        ctrl,
  // element being inserted, broadcast to all cells
  input  logic [KEY_BITS-1:0]         new_pri,
  input  logic [KEY_BITS-1:0]         new_sec,
  input  logic [tkis_pkg::POS_BITS-1:0] new_pos,
  // neighbor toward the head
  input  logic                        left_lt,
  input  logic                        left_valid,
  input  logic [KEY_BITS-1:0]         left_pri,
  input  logic [KEY_BITS-1:0]         left_sec,
  input  logic [tkis_pkg::POS_BITS-1:0] left_pos,
  // neighbor toward the tail
  input  logic                        right_valid,
  input  logic [KEY_BITS-1:0]         right_pri,
  input  logic [KEY_BITS-1:0]         right_sec,
  input  logic [tkis_pkg::POS_BITS-1:0] right_pos,
  // contents of this cell
  output logic                        valid,
  output logic [KEY_BITS-1:0]         pri,
  output logic [KEY_BITS-1:0]         sec,
  output logic [tkis_pkg::POS_BITS-1:0] pos,
  output logic                        lt
);
  import tkis_pkg::*;

  logic pri_less;
  logic pri_equal;
  logic sec_less;

  // New element ranks ahead of the stored one. Its load position is always
  // later, so full key equality keeps the stored one in front.
  assign pri_less  = $signed(new_pri) < $signed(pri);
  assign pri_equal = new_pri == pri;
  assign sec_less  = $signed(new_sec) < $signed(sec);
  assign lt        = !valid || pri_less || (pri_equal && sec_less);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert) begin
      if (left_lt) begin
        valid <= left_valid;
      end else if (lt) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pri <= right_pri;
      sec <= right_sec;
      pos <= right_pos;
    end else if (ctrl.insert) begin
      if (left_lt) begin
        pri <= left_pri;
        sec <= left_sec;
        pos <= left_pos;
      end else if (lt) begin
        pri <= new_pri;
        sec <= new_sec;
        pos <= new_pos;
      end
    end
  end

endmodule

@@ src/two_key_index_sorter_top.sv @@
// ----------------------------------------------------------------------------
// two_key_index_sorter_top
// Insertion-sorting chain that returns load positions in two-key order.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, primary_key, secondary_key, | into block
//          | last_element                                    |
//  out     | out_valid, out_ready, position, last_rank,      | out of block
//          | overflow                                        |
//
// Unless the chain is full, the chain of cells places each accepted element of
// a list in sorted order in the cycle it is accepted. After the last element,
// the chain drains one result per cycle from its head cell while out_ready is
// high. No element is accepted while draining.
// Reset (rst, synchronous) empties the chain and clears count and overflow.
// A stall on the result side holds the head cell and its payload unchanged.
// ----------------------------------------------------------------------------
module two_key_index_sorter_top #(
  parameter int MAX_ELEMENTS = tkis_pkg::DEF_MAX_ELEMENTS,
  parameter int KEY_BITS     = tkis_pkg::DEF_KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [KEY_BITS-1:0]           primary_key,
  input  logic [KEY_BITS-1:0]           secondary_key,
  input  logic                          last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tkis_pkg::POS_BITS-1:0] position,
  output logic                          last_rank,
  output logic                          overflow
);
  import tkis_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ELEMENTS + 1);

  // State codes: loading elements, or draining the sorted run.
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                state;
  logic                state_next;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                overflowed;
  logic                overflowed_next;

  logic       in_xfer;
  logic       out_xfer;
  logic       full;
  cell_ctrl_t ctrl;

  // Chain contents, one entry per cell.
  logic                c_valid [MAX_ELEMENTS];
  logic [KEY_BITS-1:0] c_pri   [MAX_ELEMENTS];
  logic [KEY_BITS-1:0] c_sec   [MAX_ELEMENTS];
  logic [POS_BITS-1:0] c_pos   [MAX_ELEMENTS];
  logic                c_lt    [MAX_ELEMENTS];

  assign in_ready = (state == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (state == ST_DRAIN);
  assign out_xfer  = out_valid && out_ready;
  assign full      = (count == CNT_BITS'(MAX_ELEMENTS));

  // Insert only while there is room; a transaction beyond capacity is dropped.
  // Shift the chain toward the head on every result taken.
  assign ctrl = '{insert: in_xfer && !full, shift: out_xfer};

  // Head cell drives the result channel; the run ends when the next cell is empty.
  assign position  = c_pos[0];
  assign last_rank = !c_valid[1];
  assign overflow  = overflowed;

  always_comb begin
    state_next      = state;
    count_next      = count;
    overflowed_next = overflowed;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            overflowed_next = 1'b1;
          end else begin
            count_next = count + CNT_BITS'(1);
          end
          if (last_element) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // Drop back to loading once the final rank is taken.
        if (out_xfer && last_rank) begin
          state_next      = ST_LOAD;
          count_next      = '0;
          overflowed_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      overflowed <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      overflowed <= overflowed_next;
    end
  end

  // Row of cells: the head cell has nothing on its left, the tail cell
  // takes an empty slot from its right when the chain shifts.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic                l_lt;
    logic                l_valid;
    logic [KEY_BITS-1:0] l_pri;
    logic [KEY_BITS-1:0] l_sec;
    logic [POS_BITS-1:0] l_pos;
    logic                r_valid;
    logic [KEY_BITS-1:0] r_pri;
    logic [KEY_BITS-1:0] r_sec;
    logic [POS_BITS-1:0] r_pos;

    if (i == 0) begin : g_head
      assign l_lt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_pri   = primary_key;
      assign l_sec   = secondary_key;
      assign l_pos   = POS_BITS'(count);
    end else begin : g_body
      assign l_lt    = c_lt[i-1];
      assign l_valid = c_valid[i-1];
      assign l_pri   = c_pri[i-1];
      assign l_sec   = c_sec[i-1];
      assign l_pos   = c_pos[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_pri   = c_pri[i];
      assign r_sec   = c_sec[i];
      assign r_pos   = c_pos[i];
    end else begin : g_inner
      assign r_valid = c_valid[i+1];
      assign r_pri   = c_pri[i+1];
      assign r_sec   = c_sec[i+1];
      assign r_pos   = c_pos[i+1];
    end

    tkis_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_pri     (primary_key),
      .new_sec     (secondary_key),
      .new_pos     (POS_BITS'(count)),
      .left_lt     (l_lt),
      .left_valid  (l_valid),
      .left_pri    (l_pri),
      .left_sec    (l_sec),
      .left_pos    (l_pos),
      .right_valid (r_valid),
      .right_pri   (r_pri),
      .right_sec   (r_sec),
      .right_pos   (r_pos),
      .valid       (c_valid[i]),
      .pri         (c_pri[i]),
      .sec         (c_sec[i]),
      .pos         (c_pos[i]),
      .lt          (c_lt[i])
    );
  end

endmodule
